### design/fsns_pkg.sv
// ----------------------------------------------------------------------------
// fsns_pkg - shared definitions for the nearest-neighbor frame store scaler
// Request codes, register indexes, palette and color expansion helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package fsns_pkg;

	localparam int DEF_SRC_WIDTH  = 160;
	localparam int DEF_SRC_HEIGHT = 144;

	localparam int PIX_W   = 24;
	localparam int RATIO_W = 20;
	localparam int HOFS_W  = 9;
	localparam int SKIP_W  = 4;
	localparam int COORD_W = 10;
	localparam int SCOL_W  = 11;
	localparam int CFG_W   = 20;
	localparam int PROD_W  = COORD_W + RATIO_W;
	localparam int FRAC_W  = 16;

	typedef enum logic [1:0] {
		MODE_MONO      = 2'd0,
		MODE_COLOR     = 2'd1,
		MODE_FRAME_END = 2'd2,
		MODE_READ      = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REG_X_STEP   = 2'd0,
		REG_Y_STEP   = 2'd1,
		REG_H_OFFSET = 2'd2,
		REG_SKIP     = 2'd3
	} reg_index_t;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_PIXEL  = 1'b1;

	localparam logic [RATIO_W-1:0] X_STEP_RESET = 20'd39421;
	localparam logic [RATIO_W-1:0] Y_STEP_RESET = 20'd39322;
	localparam logic [HOFS_W-1:0]  H_OFS_RESET  = 9'd27;
	localparam logic [SKIP_W-1:0]  SKIP_RESET   = 4'd3;
	// 1.0 in 4.16, makes the scaler pass write coordinates through
	localparam logic [RATIO_W-1:0] UNIT_STEP    = 20'h10000;

	typedef struct packed {
		logic we;
		logic re;
	} store_ctl_t;

	function automatic logic [PIX_W-1:0] shade_rgb(input logic [1:0] shade);
		logic [PIX_W-1:0] c;
		unique case (shade)
			2'd0: c = 24'h75A32C;
			2'd1: c = 24'h387A21;
			2'd2: c = 24'h255116;
			2'd3: c = 24'h12280B;
			default: c = 24'h75A32C;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] widen5(input logic [4:0] v);
		return {v, v[4:2]};
	endfunction

	function automatic logic [PIX_W-1:0] rgb555_to_888(input logic [14:0] c);
		return {widen5(c[4:0]), widen5(c[9:5]), widen5(c[14:10])};
	endfunction

endpackage

`default_nettype wire

### design/frame_store_nearest_scaler_core.sv
// ----------------------------------------------------------------------------
// frame_store_nearest_scaler_core - frame store with nearest-neighbor readout
// Pixel writes, frame end status and scaled pixel reads over one RAM.
// ----------------------------------------------------------------------------
// Takes one request per cycle whenever the output is not stalled. The pipeline
// is: step multiply, saturate, address multiply, then the RAM read straight
// into the output register. Writes and reads use the one RAM port at the
// same stage, so they stay in request order and a read always sees every
// earlier write. A stalled result freezes the whole pipeline and input stall
// follows it. The frame store has no reset and no clearing pass; the skip
// counter is updated as a frame end request is taken, which is also where
// writes sample it.
`default_nettype none

module frame_store_nearest_scaler_core
	import fsns_pkg::*;
#(
	parameter int SRC_WIDTH  = DEF_SRC_WIDTH,
	parameter int SRC_HEIGHT = DEF_SRC_HEIGHT
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         mode,
	input  wire logic [COORD_W-1:0] row,
	input  wire logic [COORD_W-1:0] column,
	input  wire logic [14:0]        color_in,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    result_kind,
	output logic [PIX_W-1:0]        pixel_rgb,
	output logic [SCOL_W-1:0]       screen_column,
	output logic                    frame_shown,
	input  wire logic               wr_en,
	input  wire logic [1:0]         wr_index,
	input  wire logic [CFG_W-1:0]   wr_data
);

	localparam int DEPTH = SRC_WIDTH * SRC_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int XW    = $clog2(SRC_WIDTH);
	localparam int YW    = $clog2(SRC_HEIGHT);
	localparam int IW    = PROD_W - FRAC_W;
	localparam logic [IW-1:0] W_LIM  = IW'(SRC_WIDTH);
	localparam logic [IW-1:0] H_LIM  = IW'(SRC_HEIGHT);
	localparam logic [XW-1:0] X_LAST = XW'(SRC_WIDTH - 1);
	localparam logic [YW-1:0] Y_LAST = YW'(SRC_HEIGHT - 1);
	localparam logic [AW-1:0] W_A    = AW'(SRC_WIDTH);

	// configuration
	logic [RATIO_W-1:0] x_step_q, y_step_q;
	logic [HOFS_W-1:0]  h_ofs_q;
	logic [SKIP_W-1:0]  skip_reload_q, skip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_step_q      <= X_STEP_RESET;
			y_step_q      <= Y_STEP_RESET;
			h_ofs_q       <= H_OFS_RESET;
			skip_reload_q <= SKIP_RESET;
		end else if (wr_en) begin
			unique case (reg_index_t'(wr_index))
				REG_X_STEP:   x_step_q      <= wr_data[RATIO_W-1:0];
				REG_Y_STEP:   y_step_q      <= wr_data[RATIO_W-1:0];
				REG_H_OFFSET: h_ofs_q       <= wr_data[HOFS_W-1:0];
				REG_SKIP:     skip_reload_q <= wr_data[SKIP_W-1:0];
				default: ;
			endcase
		end
	end

	logic advance, accept;
	assign in_stall = out_valid && out_stall;
	assign advance  = !in_stall;
	assign accept   = in_valid && advance;

	mode_t m;
	logic  is_rd, is_fe, is_wr, wr_ok;
	assign m     = mode_t'(mode);
	assign is_rd = (m == MODE_READ);
	assign is_fe = (m == MODE_FRAME_END);
	assign is_wr = (m == MODE_MONO) || (m == MODE_COLOR);
	assign wr_ok = is_wr && (skip_q == '0)
		&& (row < COORD_W'(SRC_HEIGHT)) && (column < COORD_W'(SRC_WIDTH));

	// frame skip counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= '0;
		end else if (accept && is_fe) begin
			if (skip_q != '0) begin
				skip_q <= skip_q - 1'b1;
			end else begin
				skip_q <= skip_reload_q;
			end
		end
	end

	// stage 1: step multiply (writes use a unit step)
	logic [RATIO_W-1:0] x_mul, y_mul;
	assign x_mul = is_rd ? x_step_q : UNIT_STEP;
	assign y_mul = is_rd ? y_step_q : UNIT_STEP;

	logic               res_s1, wr_s1, kind_s1, shown_s1;
	logic [SCOL_W-1:0]  scol_s1;
	logic [PIX_W-1:0]   wdata_s1;
	logic [PROD_W-1:0]  px_s1, py_s1;

	logic               res_s2, wr_s2, kind_s2, shown_s2;
	logic [SCOL_W-1:0]  scol_s2;
	logic [PIX_W-1:0]   wdata_s2;
	logic [XW-1:0]      x_s2;
	logic [YW-1:0]      y_s2;

	logic               res_s3, wr_s3, kind_s3, shown_s3;
	logic [SCOL_W-1:0]  scol_s3;
	logic [PIX_W-1:0]   wdata_s3;
	logic [AW-1:0]      addr_s3;

	logic               kind_s4, shown_s4;
	logic [SCOL_W-1:0]  scol_s4;
	logic [PIX_W-1:0]   rdata_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s1    <= 1'b0;
			wr_s1     <= 1'b0;
			res_s2    <= 1'b0;
			wr_s2     <= 1'b0;
			res_s3    <= 1'b0;
			wr_s3     <= 1'b0;
			out_valid <= 1'b0;
		end else if (advance) begin
			res_s1    <= in_valid && (is_rd || is_fe);
			wr_s1     <= in_valid && wr_ok;
			res_s2    <= res_s1;
			wr_s2     <= wr_s1;
			res_s3    <= res_s2;
			wr_s3     <= wr_s2;
			out_valid <= res_s3;
		end
	end

	logic [IW-1:0] sx_full, sy_full;
	assign sx_full = px_s1[PROD_W-1:FRAC_W];
	assign sy_full = py_s1[PROD_W-1:FRAC_W];

	always_ff @(posedge clk) begin
		if (advance) begin
			kind_s1  <= is_rd ? KIND_PIXEL : KIND_STATUS;
			shown_s1 <= is_fe && (skip_q == '0);
			scol_s1  <= is_rd ? (SCOL_W'(column) + SCOL_W'(h_ofs_q)) : '0;
			wdata_s1 <= (m == MODE_MONO) ? shade_rgb(color_in[1:0])
				: rgb555_to_888(color_in);
			px_s1    <= PROD_W'(column) * PROD_W'(x_mul);
			py_s1    <= PROD_W'(row) * PROD_W'(y_mul);

			// stage 2: saturate to the last column or line
			kind_s2  <= kind_s1;
			shown_s2 <= shown_s1;
			scol_s2  <= scol_s1;
			wdata_s2 <= wdata_s1;
			x_s2     <= (sx_full >= W_LIM) ? X_LAST : sx_full[XW-1:0];
			y_s2     <= (sy_full >= H_LIM) ? Y_LAST : sy_full[YW-1:0];

			// stage 3: linear address
			kind_s3  <= kind_s2;
			shown_s3 <= shown_s2;
			scol_s3  <= scol_s2;
			wdata_s3 <= wdata_s2;
			addr_s3  <= (AW'(y_s2) * W_A) + AW'(x_s2);

			// stage 4: result register, read data comes from the store
			kind_s4  <= kind_s3;
			shown_s4 <= shown_s3;
			scol_s4  <= scol_s3;
		end
	end

	store_ctl_t st_ctl;
	assign st_ctl.we = advance && wr_s3;
	assign st_ctl.re = advance && res_s3 && (kind_s3 == KIND_PIXEL);

	fsns_store #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_store (
		.clk  (clk),
		.ctl  (st_ctl),
		.addr (addr_s3),
		.wdata(wdata_s3),
		.rdata(rdata_s4)
	);

	assign result_kind   = kind_s4;
	assign pixel_rgb     = (kind_s4 == KIND_PIXEL) ? rdata_s4 : '0;
	assign screen_column = scol_s4;
	assign frame_shown   = shown_s4;

	// a skipped frame end counts down by one
	a_skip_dec: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_fe && (skip_q != '0) |=> skip_q == $past(skip_q) - 1'b1)
		else $error("skip counter did not count down");

	// a shown frame end reloads the counter
	a_skip_reload: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_fe && (skip_q == '0) |=> skip_q == $past(skip_reload_q))
		else $error("skip counter not reloaded");

	// the store port never sees a write and a read together
	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({st_ctl.we, st_ctl.re}))
		else $error("store write and read in one cycle");

	// a status result carries the shown flag only, a pixel never does
	a_status_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind == KIND_PIXEL) |-> !frame_shown)
		else $error("pixel result marked as shown frame");

endmodule

`default_nettype wire

### design/fsns_store.sv
// ----------------------------------------------------------------------------
// fsns_store - source frame memory
// Single port synchronous RAM, one write or one read per cycle, read data
// registered.
// ----------------------------------------------------------------------------
`default_nettype none

module fsns_store
	import fsns_pkg::*;
#(
	parameter int DEPTH = DEF_SRC_WIDTH * DEF_SRC_HEIGHT,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire store_ctl_t       ctl,
	input  wire logic [AW-1:0]    addr,
	input  wire logic [PIX_W-1:0] wdata,
	output logic      [PIX_W-1:0] rdata
);

	logic [PIX_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[addr] <= wdata;
		end
		if (ctl.re) begin
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for frame_store_nearest_scaler_core
// Drives pixel writes, frame ends and scaled reads with random gaps on both
// sides and checks every result against a cycle-free model of the frame
// store, the skip counter and the nearest-neighbor scaler.
// ----------------------------------------------------------------------------
module tb_top;
	import fsns_pkg::*;

	localparam int SRC_W = DEF_SRC_WIDTH;
	localparam int SRC_H = DEF_SRC_HEIGHT;
	localparam int SETTLE = 10;
	localparam int unsigned LIMIT = 400000;

	typedef struct packed {
		mode_t       op;
		logic [9:0]  row_n;
		logic [9:0]  col_n;
		logic [14:0] color;
	} request_t;

	typedef struct packed {
		logic        kind;
		logic [23:0] rgb;
		logic [10:0] scol;
		logic        shown;
	} outcome_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	request_t offer = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic result_kind;
	logic [PIX_W-1:0] pixel_rgb;
	logic [SCOL_W-1:0] screen_column;
	logic frame_shown;
	logic wr_en = 1'b0;
	logic [1:0] wr_index = '0;
	logic [CFG_W-1:0] wr_data = '0;

	frame_store_nearest_scaler_core #(
		.SRC_WIDTH(SRC_W),
		.SRC_HEIGHT(SRC_H)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(offer.op),
		.row(offer.row_n),
		.column(offer.col_n),
		.color_in(offer.color),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_kind(result_kind),
		.pixel_rgb(pixel_rgb),
		.screen_column(screen_column),
		.frame_shown(frame_shown),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// model state, advanced as requests are accepted
	localparam logic [23:0] GREEN_SHADES [4] = '{24'h75A32C, 24'h387A21, 24'h255116, 24'h12280B};
	logic [23:0] frame_model [SRC_W*SRC_H];
	logic [3:0] skips_left = '0;
	logic [19:0] x_ratio = X_STEP_RESET;
	logic [19:0] y_ratio = Y_STEP_RESET;
	logic [8:0] h_offset = H_OFS_RESET;
	logic [3:0] skip_reload_r = SKIP_RESET;
	outcome_t awaited_results [$];

	// planning state, advanced as requests are queued
	request_t pending_requests [$];
	bit laid [SRC_W*SRC_H];
	int laid_list [$];
	logic [3:0] plan_skips = '0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit squeeze_go = 1'b0;
	bit squeeze_done = 1'b0;
	int hold_left = 0;
	int errors = 0;
	int unsigned cycle_count = 0;

	function automatic logic [23:0] rgb_from_555(logic [14:0] c);
		return {c[4:0], c[4:2], c[9:5], c[9:7], c[14:10], c[14:12]};
	endfunction

	function automatic int unsigned nearest_src(logic [9:0] pos, logic [19:0] ratio,
			int unsigned lim);
		longint unsigned p;
		longint unsigned s;
		p = pos;
		s = (p * ratio) >> 16;
		return (s >= lim) ? lim - 1 : 32'(s);
	endfunction

	function automatic void predict_request(request_t q);
		outcome_t o;
		int unsigned sx;
		int unsigned sy;
		o = '0;
		case (q.op)
			MODE_MONO, MODE_COLOR: begin
				if (skips_left == 0 && q.row_n < SRC_H && q.col_n < SRC_W)
					frame_model[q.row_n * SRC_W + q.col_n] = (q.op == MODE_MONO) ?
						GREEN_SHADES[q.color[1:0]] : rgb_from_555(q.color);
				return;
			end
			MODE_FRAME_END: begin
				o.kind = KIND_STATUS;
				if (skips_left != 0) begin
					skips_left = skips_left - 1'b1;
					o.shown = 1'b0;
				end else begin
					skips_left = skip_reload_r;
					o.shown = 1'b1;
				end
			end
			default: begin
				sx = nearest_src(q.col_n, x_ratio, SRC_W);
				sy = nearest_src(q.row_n, y_ratio, SRC_H);
				o.kind = KIND_PIXEL;
				o.rgb = frame_model[sy * SRC_W + sx];
				o.scol = 11'(q.col_n) + 11'(h_offset);
			end
		endcase
		awaited_results.push_back(o);
	endfunction

	function automatic bit plan_write(mode_t op, logic [9:0] r, logic [9:0] c,
			logic [14:0] color);
		int spot;
		pending_requests.push_back('{op: op, row_n: r, col_n: c, color: color});
		if (plan_skips != 0 || r >= SRC_H || c >= SRC_W)
			return 1'b0;
		spot = r * SRC_W + c;
		if (!laid[spot]) begin
			laid[spot] = 1'b1;
			laid_list.push_back(spot);
		end
		return 1'b1;
	endfunction

	function automatic void plan_frame_end();
		pending_requests.push_back('{op: MODE_FRAME_END,
			row_n: 10'($urandom_range(0, 1023)),
			col_n: 10'($urandom_range(0, 1023)),
			color: 15'($urandom_range(0, 32767))});
		if (plan_skips != 0)
			plan_skips = plan_skips - 1'b1;
		else
			plan_skips = skip_reload_r;
	endfunction

	function automatic void plan_read(logic [9:0] r, logic [9:0] c);
		pending_requests.push_back('{op: MODE_READ, row_n: r, col_n: c,
			color: 15'($urandom_range(0, 32767))});
	endfunction

	// output position that lands on source index s, with some jitter
	function automatic int unsigned aim_at(int unsigned s, logic [19:0] ratio);
		longint unsigned lo;
		longint unsigned span;
		if (ratio == 0)
			return $urandom_range(0, 1023);
		lo = ((longint'(s) << 16) + ratio - 1) / ratio;
		span = 65535 / ratio;
		if (span > 1023)
			span = 1023;
		return 32'(lo + $urandom_range(0, 32'(span)));
	endfunction

	// reads may only land on pixels written since reset
	function automatic bit pick_read(output logic [9:0] r, output logic [9:0] c);
		int unsigned pr;
		int unsigned pc;
		int spot;
		r = '0;
		c = '0;
		for (int k = 0; k < 24; k++) begin
			if (k < 6 || laid_list.size() == 0) begin
				pr = $urandom_range(0, 1) ? $urandom_range(0, 1023) : $urandom_range(0, 63);
				pc = $urandom_range(0, 1) ? $urandom_range(0, 1023) : $urandom_range(0, 63);
			end else begin
				spot = laid_list[$urandom_range(0, laid_list.size() - 1)];
				pr = aim_at(spot / SRC_W, y_ratio);
				pc = aim_at(spot % SRC_W, x_ratio);
			end
			if (pr < 1024 && pc < 1024 && laid[nearest_src(pr[9:0], y_ratio, SRC_H) * SRC_W +
					nearest_src(pc[9:0], x_ratio, SRC_W)]) begin
				r = pr[9:0];
				c = pc[9:0];
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// frames of writes, a few reads and a frame end; some frames are left open
	function automatic void fill_random(int budget);
		int counted;
		int nw;
		int nr;
		logic [9:0] r;
		logic [9:0] c;
		counted = 0;
		while (counted < budget) begin
			nw = (plan_skips != 0) ? $urandom_range(0, 3) : $urandom_range(3, 24);
			for (int k = 0; k < nw; k++) begin
				if ($urandom_range(0, 9) == 0) begin
					r = 10'($urandom_range(0, 1023));
					c = 10'($urandom_range(0, 1023));
				end else begin
					r = 10'($urandom_range(0, SRC_H - 1));
					c = 10'($urandom_range(0, SRC_W - 1));
				end
				if (plan_write(mode_t'($urandom_range(0, 1)), r, c,
						15'($urandom_range(0, 32767))))
					counted++;
				if ($urandom_range(0, 29) == 0) begin
					plan_frame_end();
					counted++;
				end
			end
			nr = $urandom_range(1, 8);
			for (int k = 0; k < nr; k++) begin
				if (pick_read(r, c)) begin
					plan_read(r, c);
					counted++;
				end
			end
			if ($urandom_range(0, 9) != 0) begin
				plan_frame_end();
				counted++;
			end
		end
	endfunction

	task automatic flag_fault(string msg);
		errors++;
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
	endtask

	task automatic set_register(reg_index_t idx, logic [19:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_X_STEP:   x_ratio = val;
			REG_Y_STEP:   y_ratio = val;
			REG_H_OFFSET: h_offset = val[8:0];
			default:      skip_reload_r = val[3:0];
		endcase
	endtask

	task automatic configure(logic [19:0] xs, logic [19:0] ys, logic [8:0] ofs,
			logic [3:0] reload);
		set_register(REG_X_STEP, xs);
		set_register(REG_Y_STEP, ys);
		set_register(REG_H_OFFSET, {11'd0, ofs});
		set_register(REG_SKIP, {16'd0, reload});
	endtask

	// writes give no result, so let the pipeline empty after the last one
	task automatic drain();
		while (pending_requests.size() != 0 || in_valid || awaited_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic run_phase(int s_idle, int r_idle, bit squeeze, int budget);
		@(negedge clk);
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		squeeze_go = squeeze;
		fill_random(budget);
		drain();
	endtask

	initial begin : stimulus
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		send_idle_pct = 25;
		recv_idle_pct = 65;
		// corners in every shade, shade upper bits set, color extremes
		void'(plan_write(MODE_MONO, 10'd0, 10'd0, 15'h7FFC));
		void'(plan_write(MODE_MONO, 10'd0, 10'd159, 15'h0001));
		void'(plan_write(MODE_MONO, 10'd143, 10'd0, 15'h0002));
		void'(plan_write(MODE_MONO, 10'd143, 10'd159, 15'h7FFF));
		void'(plan_write(MODE_COLOR, 10'd1, 10'd1, 15'h7FFF));
		void'(plan_write(MODE_COLOR, 10'd0, 10'd1, 15'h0000));
		void'(plan_write(MODE_COLOR, 10'd1, 10'd0, 15'h5555));
		void'(plan_write(MODE_COLOR, 10'd1, 10'd2, 15'h2AAA));
		// writes past the frame are dropped
		void'(plan_write(MODE_MONO, 10'd144, 10'd0, 15'h0003));
		void'(plan_write(MODE_COLOR, 10'd0, 10'd160, 15'h1234));
		void'(plan_write(MODE_COLOR, 10'd1023, 10'd1023, 15'h7FFF));
		// reads at the extremes saturate onto the corners
		plan_read(10'd0, 10'd0);
		plan_read(10'd0, 10'd1023);
		plan_read(10'd1023, 10'd0);
		plan_read(10'd1023, 10'd1023);
		plan_read(10'd2, 10'd2);
		plan_frame_end();
		// skipping: write dropped, read still answered
		void'(plan_write(MODE_COLOR, 10'd5, 10'd5, 15'h7C1F));
		plan_read(10'd0, 10'd0);
		plan_frame_end();
		plan_frame_end();
		plan_frame_end();
		plan_frame_end();
		drain();

		configure(20'd1, 20'hFFFFF, 9'd511, 4'd0);
		run_phase(25, 65, 1'b0, 250);
		configure(20'hFFFFF, 20'd1, 9'd0, 4'd15);
		run_phase(25, 65, 1'b0, 250);
		configure(20'd0, 20'd0, 9'd300, 4'd1);
		run_phase(65, 25, 1'b0, 250);
		configure(UNIT_STEP, UNIT_STEP, 9'd128, 4'd2);
		run_phase(65, 25, 1'b0, 250);
		configure(20'($urandom_range(1, 20'h30000)), 20'($urandom_range(1, 20'h30000)),
			9'($urandom_range(0, 511)), 4'($urandom_range(0, 4)));
		run_phase(0, 0, 1'b1, 250);
		configure(X_STEP_RESET, Y_STEP_RESET, H_OFS_RESET, SKIP_RESET);
		run_phase(0, 0, 1'b0, 250);

		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin : request_driver
		request_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				predict_request(offer);
			if (!in_valid || !in_stall) begin
				if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					nxt = pending_requests.pop_front();
					offer <= nxt;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// one long hold-off so the pipeline backs up into the input
	always @(posedge clk or negedge arst_n) begin : long_hold
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (squeeze_go && !squeeze_done) begin
			hold_left <= 400;
			squeeze_done <= 1'b1;
		end
	end

	always @(posedge clk or negedge arst_n) begin : result_monitor
		outcome_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					flag_fault($sformatf("result with nothing awaited, kind %0d", result_kind));
				end else begin
					want = awaited_results.pop_front();
					if (result_kind !== want.kind)
						flag_fault($sformatf("result_kind %0d, want %0d", result_kind, want.kind));
					if (pixel_rgb !== want.rgb)
						flag_fault($sformatf("pixel_rgb %06h, want %06h", pixel_rgb, want.rgb));
					if (screen_column !== want.scol)
						flag_fault($sformatf("screen_column %0d, want %0d", screen_column, want.scol));
					if (frame_shown !== want.shown)
						flag_fault($sformatf("frame_shown %0d, want %0d", frame_shown, want.shown));
				end
			end
			if (hold_left != 0)
				out_stall <= 1'b1;
			else
				out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAILURE");
			$finish;
		end
	end

endmodule
